FILE: rtl/core/hsort_pkg.sv
// Shared types, sizes and the key-pair compare for the two-key heapsort core.
// No dependencies; used by heapsort_two_key_payload_core.
package hsort_pkg;

  localparam int unsigned MaxItemsDefault = 64;

  typedef struct packed {
    logic signed [31:0] primary_key;
    logic signed [31:0] secondary_key;
    logic        [63:0] payload_bits;
    logic               last_item;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] out_primary_key;
    logic signed [31:0] out_secondary_key;
    logic        [63:0] out_payload_bits;
    logic               out_last;
    logic               dropped;
  } out_word_t;

  // One stored record: what the heap moves around.
  typedef struct packed {
    logic signed [31:0] pkey;
    logic signed [31:0] skey;
    logic        [63:0] pay;
  } record_t;

  // True when (a.pkey, a.skey) > (b.pkey, b.skey), signed lexicographic.
  // Flipping both sign bits turns it into one 64-bit unsigned compare.
  function automatic logic pair_gt(record_t a, record_t b);
    logic [63:0] ka;
    logic [63:0] kb;
    ka = {~a.pkey[31], a.pkey[30:0], ~a.skey[31], a.skey[30:0]};
    kb = {~b.pkey[31], b.pkey[30:0], ~b.skey[31], b.skey[30:0]};
    return ka > kb;
  endfunction

endpackage

FILE: rtl/core/heapsort_two_key_payload_core.sv
// A plain record is written straight into the store as it is accepted. The record marked last starts an in-place
// heapsort of the n stored records: each sift-down level uses the one pair comparator
// twice (children, then held record), and each sift pass first fetches the record to sift;
// each result is then read, registered and held until out_ready takes it.
// Throughput is set by the single comparator and the 1-write/2-read record store.
// Reset (synchronous, rst_n low) clears count, overflow flag and control; the store is not cleared.
module heapsort_two_key_payload_core #(
  parameter int unsigned MAX_ITEMS = hsort_pkg::MaxItemsDefault
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  hsort_pkg::in_word_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output hsort_pkg::out_word_t out_data
);

  localparam int unsigned AW = $clog2(MAX_ITEMS);
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

  localparam logic [3:0] ST_LOAD     = 4'd0;
  localparam logic [3:0] ST_BUILD_RD = 4'd1;
  localparam logic [3:0] ST_HOLD     = 4'd2;
  localparam logic [3:0] ST_TEST     = 4'd3;
  localparam logic [3:0] ST_CMP_CH   = 4'd4;
  localparam logic [3:0] ST_CMP_H    = 4'd5;
  localparam logic [3:0] ST_NEXT     = 4'd6;
  localparam logic [3:0] ST_SWAP_RD  = 4'd7;
  localparam logic [3:0] ST_SWAP_WR  = 4'd8;
  localparam logic [3:0] ST_OUT_RD   = 4'd9;
  localparam logic [3:0] ST_OUT_SET  = 4'd10;
  localparam logic [3:0] ST_OUT_WAIT = 4'd11;

  // record store: one write port, two registered read ports
  hsort_pkg::record_t mem [MAX_ITEMS];
  hsort_pkg::record_t rd0_r, rd1_r;
  logic [AW-1:0]      ra0, ra1, wa;
  logic               we;
  hsort_pkg::record_t wd;

  logic [3:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          ovf_r, ovf_nxt;
  logic [CW-1:0] hn_r, hn_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [CW-1:0] bk_r, bk_nxt;
  logic [CW-1:0] c_r, c_nxt;
  logic [CW-1:0] oi_r, oi_nxt;
  logic          build_r, build_nxt;
  logic          out_valid_r, out_valid_nxt;
  hsort_pkg::record_t   h_r, h_nxt;
  hsort_pkg::record_t   best_r, best_nxt;
  hsort_pkg::out_word_t out_word_r, out_word_nxt;

  hsort_pkg::record_t cmp_a, cmp_b;
  logic               cmp_gt;

  logic [CW:0]   c2;
  logic [CW:0]   lft;
  logic [CW-1:0] km1;
  logic [CW-1:0] half;
  logic          room;
  logic [CW-1:0] cnt_new;
  logic [CW-1:0] cnt_m1;
  logic          in_acc;
  hsort_pkg::record_t in_rec;

  assign in_ready  = (state_r == ST_LOAD);
  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;
  assign in_acc    = in_valid && in_ready;

  assign c2      = {k_r, 1'b0};
  assign lft     = c2 - (CW + 1)'(1);
  assign km1     = k_r - CW'(1);
  assign half    = hn_r >> 1;
  assign room    = (cnt_r < CW'(MAX_ITEMS));
  assign cnt_new = room ? cnt_r + CW'(1) : cnt_r;
  assign cnt_m1  = cnt_r - CW'(1);
  assign in_rec  = '{pkey: in_data.primary_key, skey: in_data.secondary_key,
                     pay: in_data.payload_bits};

  // shared comparator: children against each other, then held record against winner
  always_comb begin
    if (state_r == ST_CMP_CH) begin
      cmp_a = rd1_r;
      cmp_b = rd0_r;
    end else begin
      cmp_a = h_r;
      cmp_b = best_r;
    end
    cmp_gt = hsort_pkg::pair_gt(cmp_a, cmp_b);
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    hn_nxt        = hn_r;
    k_nxt         = k_r;
    bk_nxt        = bk_r;
    c_nxt         = c_r;
    oi_nxt        = oi_r;
    build_nxt     = build_r;
    out_valid_nxt = out_valid_r;
    h_nxt         = h_r;
    best_nxt      = best_r;
    out_word_nxt  = out_word_r;
    ra0           = '0;
    ra1           = '0;
    we            = 1'b0;
    wa            = '0;
    wd            = h_r;

    unique case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (room) begin
            we      = 1'b1;
            wa      = cnt_r[AW-1:0];
            wd      = in_rec;
            cnt_nxt = cnt_new;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_data.last_item) begin
            hn_nxt = cnt_new;
            if ((cnt_new >> 1) != '0) begin
              bk_nxt    = cnt_new >> 1;
              k_nxt     = cnt_new >> 1;
              build_nxt = 1'b1;
              state_nxt = ST_BUILD_RD;
            end else begin
              build_nxt = 1'b0;
              state_nxt = ST_NEXT;
            end
          end
        end
      end
      ST_BUILD_RD: begin
        ra0       = km1[AW-1:0];
        state_nxt = ST_HOLD;
      end
      ST_HOLD: begin
        h_nxt     = rd0_r;
        state_nxt = ST_TEST;
      end
      ST_TEST: begin
        if (k_r <= half) begin
          ra0       = lft[AW-1:0];
          ra1       = c2[AW-1:0];  // wraps only when the right child lies past the heap
          state_nxt = ST_CMP_CH;
        end else begin
          we        = 1'b1;
          wa        = km1[AW-1:0];
          wd        = h_r;
          state_nxt = ST_NEXT;
        end
      end
      ST_CMP_CH: begin
        // take the right child only if it exists and is strictly greater
        if ((c2 < {1'b0, hn_r}) && cmp_gt) begin
          best_nxt = rd1_r;
          c_nxt    = c2[CW-1:0] + CW'(1);
        end else begin
          best_nxt = rd0_r;
          c_nxt    = c2[CW-1:0];
        end
        state_nxt = ST_CMP_H;
      end
      ST_CMP_H: begin
        we = 1'b1;
        wa = km1[AW-1:0];
        if (cmp_gt) begin
          wd        = h_r;
          state_nxt = ST_NEXT;
        end else begin
          wd        = best_r;
          k_nxt     = c_r;
          state_nxt = ST_TEST;
        end
      end
      ST_NEXT: begin
        if (build_r && (bk_r > CW'(1))) begin
          bk_nxt    = bk_r - CW'(1);
          k_nxt     = bk_r - CW'(1);
          state_nxt = ST_BUILD_RD;
        end else begin
          build_nxt = 1'b0;
          if (hn_r > CW'(1)) begin
            hn_nxt    = hn_r - CW'(1);
            state_nxt = ST_SWAP_RD;
          end else begin
            oi_nxt    = '0;
            state_nxt = ST_OUT_RD;
          end
        end
      end
      ST_SWAP_RD: begin
        ra0       = '0;
        ra1       = hn_r[AW-1:0];
        state_nxt = ST_SWAP_WR;
      end
      ST_SWAP_WR: begin
        // old root goes to the end; old end becomes the record sifted from the root
        we        = 1'b1;
        wa        = hn_r[AW-1:0];
        wd        = rd0_r;
        h_nxt     = rd1_r;
        k_nxt     = CW'(1);
        state_nxt = ST_TEST;
      end
      ST_OUT_RD: begin
        ra0       = oi_r[AW-1:0];
        state_nxt = ST_OUT_SET;
      end
      ST_OUT_SET: begin
        out_word_nxt.out_primary_key   = rd0_r.pkey;
        out_word_nxt.out_secondary_key = rd0_r.skey;
        out_word_nxt.out_payload_bits  = rd0_r.pay;
        out_word_nxt.out_last          = (oi_r == cnt_m1);
        out_word_nxt.dropped           = ovf_r;
        out_valid_nxt                  = 1'b1;
        state_nxt                      = ST_OUT_WAIT;
      end
      ST_OUT_WAIT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (out_word_r.out_last) begin
            cnt_nxt   = '0;
            ovf_nxt   = 1'b0;
            state_nxt = ST_LOAD;
          end else begin
            oi_nxt    = oi_r + CW'(1);
            state_nxt = ST_OUT_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd0_r <= mem[ra0];
    rd1_r <= mem[ra1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      hn_r        <= '0;
      k_r         <= '0;
      bk_r        <= '0;
      c_r         <= '0;
      oi_r        <= '0;
      build_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      hn_r        <= hn_nxt;
      k_r         <= k_nxt;
      bk_r        <= bk_nxt;
      c_r         <= c_nxt;
      oi_r        <= oi_nxt;
      build_r     <= build_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    h_r        <= h_nxt;
    best_r     <= best_nxt;
    out_word_r <= out_word_nxt;
  end

  a_no_load_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while a result word is pending");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_ITEMS))
    else $error("record count past capacity");

  a_sift_node_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TEST || state_r == ST_CMP_CH || state_r == ST_CMP_H)
      |-> (k_r >= CW'(1) && k_r <= hn_r))
    else $error("sift node outside the heap");

  a_last_clears_set: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_data.out_last) |=> (in_ready && cnt_r == '0 && !ovf_r))
    else $error("set state not cleared after the final word");

endmodule

FILE: sim/heapsort_two_key_payload_core_tb.sv
// Self-checking bench for heapsort_two_key_payload_core: feeds record sets, predicts
// the sorted output stream with its own heapsort and compares every result word.
// Depends on hsort_pkg (word types) and the core RTL only.
module heapsort_two_key_payload_core_tb;

  localparam int unsigned Cap = 64;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned HoldCycles = 1500;
  localparam int unsigned TailCycles = 400;

  typedef struct {
    hsort_pkg::in_word_t w;
    bit                  drain;  // wait for every pending result before sending this word
  } stim_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  hsort_pkg::in_word_t  in_data;
  logic                 out_valid;
  logic                 out_ready;
  hsort_pkg::out_word_t out_data;

  heapsort_two_key_payload_core #(
    .MAX_ITEMS(Cap)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // record store and sorted-output prediction
  hsort_pkg::record_t   rec_store [Cap];
  int unsigned          rec_fill = 0;
  bit                   rec_over = 1'b0;
  hsort_pkg::out_word_t sorted_q [$];
  stim_t                pend_q [$];

  int unsigned err_cnt = 0;
  int unsigned results_seen = 0;
  int unsigned cycle_cnt = 0;
  logic        in_fire_q = 1'b0;

  function automatic bit pair_above(hsort_pkg::record_t a, hsort_pkg::record_t b);
    if (a.pkey != b.pkey) return $signed(a.pkey) > $signed(b.pkey);
    return $signed(a.skey) > $signed(b.skey);
  endfunction

  // 1-based sift-down; left child wins ties, held record sinks past equal pairs
  task automatic sift_record(int unsigned n, int unsigned k);
    hsort_pkg::record_t held;
    int unsigned        c;
    held = rec_store[k-1];
    while (k <= n / 2) begin
      c = k + k;
      if (c < n && pair_above(rec_store[c], rec_store[c-1])) c++;
      if (pair_above(held, rec_store[c-1])) break;
      rec_store[k-1] = rec_store[c-1];
      k = c;
    end
    rec_store[k-1] = held;
  endtask

  task automatic heapsort_store(int unsigned n);
    int                 k;
    int unsigned        m;
    hsort_pkg::record_t tmp;
    for (k = n / 2; k >= 1; k--) sift_record(n, k);
    m = n;
    while (m > 1) begin
      m--;
      tmp = rec_store[0];
      rec_store[0] = rec_store[m];
      rec_store[m] = tmp;
      sift_record(m, 1);
    end
  endtask

  task automatic absorb_word(hsort_pkg::in_word_t w);
    hsort_pkg::out_word_t o;
    if (rec_fill < Cap) begin
      rec_store[rec_fill] = '{pkey: w.primary_key, skey: w.secondary_key, pay: w.payload_bits};
      rec_fill++;
    end else begin
      rec_over = 1'b1;
    end
    if (w.last_item) begin
      heapsort_store(rec_fill);
      for (int unsigned i = 0; i < rec_fill; i++) begin
        o.out_primary_key   = rec_store[i].pkey;
        o.out_secondary_key = rec_store[i].skey;
        o.out_payload_bits  = rec_store[i].pay;
        o.out_last          = (i + 1 == rec_fill);
        o.dropped           = rec_over;
        sorted_q.push_back(o);
      end
      rec_fill = 0;
      rec_over = 1'b0;
    end
  endtask

  // stimulus helpers
  function automatic logic [31:0] pick_key(int mode);
    case (mode)
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 6)) - 3);
      default: begin
        case ($urandom_range(0, 4))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'hffff_ffff;
          3: return 32'h0000_0000;
          default: return 32'h0000_0001;
        endcase
      end
    endcase
  endfunction

  task automatic push_word(logic [31:0] pk, logic [31:0] sk, logic [63:0] pay, bit last,
                           bit drain);
    stim_t s;
    s.w.primary_key   = pk;
    s.w.secondary_key = sk;
    s.w.payload_bits  = pay;
    s.w.last_item     = last;
    s.drain           = drain;
    pend_q.push_back(s);
  endtask

  task automatic push_set(int unsigned count, bit drain);
    int mode;
    for (int unsigned i = 0; i < count; i++) begin
      mode = $urandom_range(0, 3);
      push_word(pick_key(mode), pick_key(mode == 0 ? 0 : $urandom_range(0, 2)),
                {$urandom, $urandom}, i + 1 == count, drain && i == 0);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    int unsigned total;
    int unsigned set_idx;
    rst_n = 1'b0;

    // single record at the extremes
    push_word(32'h8000_0000, 32'h7fff_ffff, '1, 1'b1, 1'b1);
    // two records, opposite extremes
    push_word(32'h7fff_ffff, 32'h8000_0000, '0, 1'b0, 1'b0);
    push_word(32'h8000_0000, 32'h8000_0000, 64'h8000_0000_0000_0001, 1'b1, 1'b0);
    // equal key pairs: payload order pins down the tie rules
    for (int i = 0; i < 5; i++) push_word(32'd7, -32'sd2, 64'(i + 1), 1'b0, i == 0);
    push_word(32'd7, -32'sd3, 64'h10, 1'b0, 1'b0);
    push_word(32'd7, -32'sd1, 64'h20, 1'b0, 1'b0);
    push_word(-32'sd7, -32'sd2, 64'h30, 1'b1, 1'b0);
    // sign handling on both keys
    push_word(32'd0, 32'd0, 64'h1, 1'b0, 1'b0);
    push_word(-32'sd1, 32'd5, 64'h2, 1'b0, 1'b0);
    push_word(32'd1, -32'sd5, 64'h3, 1'b0, 1'b0);
    push_word(32'd0, -32'sd1, 64'h4, 1'b0, 1'b0);
    push_word(32'd0, 32'd1, 64'h5, 1'b0, 1'b0);
    push_word(-32'sd1, -32'sd1, 64'h6, 1'b0, 1'b0);
    push_word(32'h7fff_ffff, 32'h7fff_ffff, 64'h5555_5555_5555_5555, 1'b0, 1'b0);
    push_word(32'h8000_0000, 32'h8000_0000, 64'haaaa_aaaa_aaaa_aaaa, 1'b1, 1'b0);

    total = pend_q.size();
    set_idx = 0;
    while (total < 230) begin
      if (set_idx == 2) begin
        // past capacity: both a plain record and the last one get dropped
        push_set(Cap + 2, 1'b1);
        total += Cap + 2;
      end else begin
        automatic int unsigned n = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 24)
                                                               : $urandom_range(1, 8);
        push_set(n, set_idx == 6);
        total += n;
      end
      set_idx++;
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (pend_q.size() != 0 || in_valid) @(posedge clk);
    while (sorted_q.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // sender: bursts with random gaps
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;

  always @(negedge clk) begin
    stim_t s;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else if (in_valid && !in_fire_q) begin
      // hold the word until taken
    end else if (gap_left != 0) begin
      gap_left--;
      in_valid <= 1'b0;
    end else if (pend_q.size() == 0 || (pend_q[0].drain && sorted_q.size() != 0)) begin
      in_valid <= 1'b0;
    end else begin
      s = pend_q.pop_front();
      in_valid <= 1'b1;
      in_data  <= s.w;
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      end
    end
  end

  // receiver: stall pattern changes mode now and then, one long hold-off
  int unsigned mode_left = 0;
  int unsigned rx_mode = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!hold_done && out_valid && results_seen >= 120) begin
      hold_done = 1'b1;
      hold_left = HoldCycles;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= (cycle_cnt[1:0] != 2'b11);
      endcase
    end
  end

  // monitor: predict on accepted input, check each accepted result
  always @(posedge clk) begin
    hsort_pkg::out_word_t want;
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("FAIL");
      $finish;
    end
    in_fire_q <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready) absorb_word(in_data);
    if (rst_n && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (sorted_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("unexpected result word: pk=%0d sk=%0d pay=%h last=%0b drop=%0b",
                   out_data.out_primary_key, out_data.out_secondary_key,
                   out_data.out_payload_bits, out_data.out_last, out_data.dropped);
      end else begin
        want = sorted_q.pop_front();
        if (out_data.out_primary_key !== want.out_primary_key ||
            out_data.out_secondary_key !== want.out_secondary_key ||
            out_data.out_payload_bits !== want.out_payload_bits ||
            out_data.out_last !== want.out_last || out_data.dropped !== want.dropped) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("mismatch at result %0d: exp pk=%0d sk=%0d pay=%h last=%0b drop=%0b,",
                     results_seen,
                     want.out_primary_key, want.out_secondary_key, want.out_payload_bits,
                     want.out_last, want.dropped,
                     " got pk=%0d sk=%0d pay=%h last=%0b drop=%0b",
                     out_data.out_primary_key,
                     out_data.out_secondary_key, out_data.out_payload_bits,
                     out_data.out_last, out_data.dropped);
        end
      end
    end
  end

endmodule

FILE: heapsort_two_key_payload_core.f
rtl/core/hsort_pkg.sv
rtl/core/heapsort_two_key_payload_core.sv
sim/heapsort_two_key_payload_core_tb.sv
